### rtl/mrde_pkg.sv
// Shared types and constants for the mini RISC decode/execute block.
`default_nettype none
package mrde_pkg;

  localparam int NUM_REGS_DEF   = 8;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH    = 2;

  localparam int INSTR_W = 16;
  localparam int IDX_W   = 3;
  localparam int IMM_W   = 6;
  localparam int VALUE_W = 32;
  localparam int OUT_W   = 40;

  localparam logic [3:0] OP_RTYPE = 4'd0;
  localparam logic [3:0] OP_ADDI  = 4'd4;
  localparam logic [3:0] OP_LW    = 4'd11;
  localparam logic [3:0] OP_SW    = 4'd15;
  localparam logic [3:0] OP_BEQ   = 4'd8;
  localparam logic [3:0] OP_J     = 4'd2;

  localparam logic [2:0] FN_ADD = 3'd0;
  localparam logic [2:0] FN_SUB = 3'd2;
  localparam logic [2:0] FN_OR  = 3'd4;
  localparam logic [2:0] FN_AND = 3'd5;

  localparam logic [2:0] ST_RTYPE   = 3'd0;
  localparam logic [2:0] ST_ADDI    = 3'd1;
  localparam logic [2:0] ST_FLAGGED = 3'd2;
  localparam logic [2:0] ST_BAD_OP  = 3'd3;
  localparam logic [2:0] ST_BAD_FN  = 3'd4;

  typedef enum logic [2:0] {
    K_ADD,
    K_SUB,
    K_OR,
    K_AND,
    K_ADDI,
    K_FLAG,
    K_BAD_OP,
    K_BAD_FN
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [IDX_W-1:0] rs;
    logic [IDX_W-1:0] rt;
    logic [IDX_W-1:0] dest;
    logic [IMM_W-1:0] imm;
  } dec_t;

endpackage
`default_nettype wire

### rtl/mini_risc_decode_execute.sv
// Top level of the mini RISC decode/execute block.
// A beat passes through the queue, the read stage and the output register,
// one instruction per cycle unless stalled; the register file is written
// as the result is registered, and the read stage takes a forwarded value.
// Reset (rst_n low, synchronous): queue, stages and output empty,
// all registers read as zero.
`default_nettype none
module mini_risc_decode_execute #(
  parameter int NUM_REGS   = mrde_pkg::NUM_REGS_DEF,
  parameter int DATA_WIDTH = mrde_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [mrde_pkg::INSTR_W-1:0] in_tdata,   // instr[15:0]
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  // status[2:0], wrote[3], dest_reg[6:4], write_value[38:7], zero[39]
  output logic [mrde_pkg::OUT_W-1:0]        out_tdata
);
  import mrde_pkg::*;

  dec_t q_wdata, q_rdata;
  logic q_push, q_full, q_valid, q_pop;

  mrde_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  mrde_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .valid (q_valid),
    .rdata (q_rdata),
    .pop   (q_pop)
  );

  mrde_back #(
    .NUM_REGS   (NUM_REGS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

### rtl/mrde_front.sv
// Front end: accepts instruction beats and classifies them into decoded ops.
`default_nettype none
module mrde_front (
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [mrde_pkg::INSTR_W-1:0] in_tdata,   // instr[15:0]
  input  wire logic                        q_full,
  output logic                             q_push,
  output mrde_pkg::dec_t                   q_wdata
);
  import mrde_pkg::*;

  logic [3:0] opcode;
  logic [2:0] funct;

  assign opcode    = in_tdata[15:12];
  assign funct     = in_tdata[2:0];
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    q_wdata.rs   = in_tdata[11:9];
    q_wdata.rt   = in_tdata[8:6];
    q_wdata.imm  = in_tdata[5:0];
    q_wdata.dest = in_tdata[5:3];
    q_wdata.kind = K_BAD_OP;
    case (opcode)
      OP_RTYPE: begin
        case (funct)
          FN_ADD:  q_wdata.kind = K_ADD;
          FN_SUB:  q_wdata.kind = K_SUB;
          FN_OR:   q_wdata.kind = K_OR;
          FN_AND:  q_wdata.kind = K_AND;
          default: q_wdata.kind = K_BAD_FN;
        endcase
      end
      OP_ADDI: begin
        q_wdata.kind = K_ADDI;
        q_wdata.dest = in_tdata[8:6];
      end
      OP_LW, OP_SW, OP_BEQ, OP_J: q_wdata.kind = K_FLAG;
      default: q_wdata.kind = K_BAD_OP;
    endcase
  end

endmodule
`default_nettype wire

### rtl/mrde_queue.sv
// Short queue of decoded ops between front and back ends.
`default_nettype none
module mrde_queue #(
  parameter int DEPTH = mrde_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire mrde_pkg::dec_t wdata,
  output logic                full,
  output logic                valid,
  output mrde_pkg::dec_t      rdata,
  input  wire logic           pop
);
  import mrde_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  dec_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign valid   = (cnt_r != '0);
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

### rtl/mrde_back.sv
// Back end: register read, ALU, writeback and output register.
`default_nettype none
module mrde_back #(
  parameter int NUM_REGS   = mrde_pkg::NUM_REGS_DEF,
  parameter int DATA_WIDTH = mrde_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      q_valid,
  input  wire mrde_pkg::dec_t            q_rdata,
  output logic                           q_pop,
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  output logic [mrde_pkg::OUT_W-1:0]     out_tdata
);
  import mrde_pkg::*;

  localparam int REG_AW = $clog2(NUM_REGS);

  logic [DATA_WIDTH-1:0] rf_r [NUM_REGS];
  logic [NUM_REGS-1:0]   rf_vld_r;

  logic                  s1_valid_r, s1_valid_nxt;
  dec_t                  s1_op_r;
  logic [DATA_WIDTH-1:0] a_r, b_r;

  logic                  out_valid_r, out_valid_nxt;
  logic [2:0]            status_r;
  logic                  wrote_r;
  logic [IDX_W-1:0]      dest_r;
  logic [VALUE_W-1:0]    value_r;

  logic                  fire, s1_load, wr_en, fwd_a, fwd_b;
  logic [DATA_WIDTH-1:0] res;
  logic [2:0]            status;
  logic [REG_AW-1:0]     wr_idx, rs_idx, rt_idx;

  assign fire    = s1_valid_r && (!out_valid_r || out_tready);
  assign s1_load = q_valid && (!s1_valid_r || fire);
  assign q_pop   = s1_load;
  assign wr_idx  = s1_op_r.dest[REG_AW-1:0];
  assign rs_idx  = q_rdata.rs[REG_AW-1:0];
  assign rt_idx  = q_rdata.rt[REG_AW-1:0];
  assign fwd_a   = fire && wr_en && (wr_idx == rs_idx);
  assign fwd_b   = fire && wr_en && (wr_idx == rt_idx);

  always_comb begin
    res    = '0;
    wr_en  = 1'b0;
    status = ST_BAD_OP;
    case (s1_op_r.kind)
      K_ADD: begin
        res = a_r + b_r; wr_en = 1'b1; status = ST_RTYPE;
      end
      K_SUB: begin
        res = a_r - b_r; wr_en = 1'b1; status = ST_RTYPE;
      end
      K_OR: begin
        res = a_r | b_r; wr_en = 1'b1; status = ST_RTYPE;
      end
      K_AND: begin
        res = a_r & b_r; wr_en = 1'b1; status = ST_RTYPE;
      end
      K_ADDI: begin
        res = a_r + DATA_WIDTH'(s1_op_r.imm); wr_en = 1'b1; status = ST_ADDI;
      end
      K_FLAG:   status = ST_FLAGGED;
      K_BAD_FN: status = ST_BAD_FN;
      default:  status = ST_BAD_OP;
    endcase
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s1_load) begin
      s1_valid_nxt = 1'b1;
    end else if (fire) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      rf_vld_r    <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (fire && wr_en) begin
        rf_vld_r[wr_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && wr_en) begin
      rf_r[wr_idx] <= res;
    end
    if (s1_load) begin
      s1_op_r <= q_rdata;
      a_r     <= fwd_a ? res : (rf_vld_r[rs_idx] ? rf_r[rs_idx] : '0);
      b_r     <= fwd_b ? res : (rf_vld_r[rt_idx] ? rf_r[rt_idx] : '0);
    end
    if (fire) begin
      status_r <= status;
      wrote_r  <= wr_en;
      dest_r   <= wr_en ? s1_op_r.dest : '0;
      value_r  <= wr_en ? VALUE_W'(res) : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, value_r, dest_r, wrote_r, status_r};

endmodule
`default_nettype wire

### rtl/mrde_checker.sv
// Port-level assertions for the mini RISC decode/execute block, with bind.
`default_nettype none
module mrde_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_tready,
  input wire logic                         out_tvalid,
  input wire logic                         out_tready,
  input wire logic [mrde_pkg::OUT_W-1:0]   out_tdata
);
  import mrde_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> in_tready)
    else $error("input not ready right after reset");

  a_wrote_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[3] == (out_tdata[2:0] == ST_RTYPE ||
                                     out_tdata[2:0] == ST_ADDI)))
    else $error("wrote flag does not match status");

  a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[3] |-> out_tdata[38:4] == '0 && !out_tdata[39])
    else $error("nonzero destination or value without a write");

endmodule

bind mini_risc_decode_execute mrde_checker u_mrde_checker (.*);
`default_nettype wire

### bench/tb_mini_risc_decode_execute.sv
// Testbench for mini_risc_decode_execute: directed and random beats against a register model.
`timescale 1ns / 100ps
module tb_mini_risc_decode_execute;
  import mrde_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RAND_ITEMS  = 540;
  localparam int DRAIN_WAIT  = 8;

  typedef struct packed {
    logic [2:0]  status;
    logic        wrote;
    logic [2:0]  dest;
    logic [31:0] value;
  } exec_res_t;

  typedef struct {
    logic [15:0] instr;
    bit          typed;
    exec_res_t   want;
  } dir_row_t;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [INSTR_W-1:0]  in_tdata   = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_W-1:0]    out_tdata;

  logic [31:0]  gpr_model [8];
  exec_res_t    pending_results [$];
  dir_row_t     directed_rows [$];
  int           fail_count  = 0;
  int           cycle_count = 0;
  int           stall_pct   = 0;

  mini_risc_decode_execute DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [15:0] r_op(logic [2:0] fn, logic [2:0] rd, logic [2:0] rs,
                                       logic [2:0] rt);
    return {OP_RTYPE, rs, rt, rd, fn};
  endfunction

  function automatic logic [15:0] i_op(logic [2:0] rt, logic [2:0] rs, logic [5:0] imm);
    return {OP_ADDI, rs, rt, imm};
  endfunction

  function automatic exec_res_t res_of(logic [2:0] st, logic wr, logic [2:0] dst,
                                       logic [31:0] val);
    exec_res_t r;
    r.status = st;
    r.wrote  = wr;
    r.dest   = dst;
    r.value  = val;
    return r;
  endfunction

  function automatic dir_row_t row(logic [15:0] w, bit typed, exec_res_t want);
    dir_row_t d;
    d.instr = w;
    d.typed = typed;
    d.want  = want;
    return d;
  endfunction

  // decode and execute one instruction, updating the register file
  function automatic exec_res_t exec_instr(logic [15:0] w);
    logic [3:0]  op;
    logic [2:0]  rs, rt, rd, fn;
    logic [5:0]  imm;
    logic [31:0] a, b, v;
    exec_res_t   r;
    op  = w[15:12];
    rs  = w[11:9];
    rt  = w[8:6];
    rd  = w[5:3];
    fn  = w[2:0];
    imm = w[5:0];
    a   = gpr_model[rs];
    b   = gpr_model[rt];
    r   = res_of(ST_BAD_OP, 1'b0, 3'd0, 32'd0);
    if (op == OP_RTYPE) begin
      r.status = ST_RTYPE;
      r.wrote  = 1'b1;
      r.dest   = rd;
      case (fn)
        FN_ADD: v = a + b;
        FN_SUB: v = a - b;
        FN_OR:  v = a | b;
        FN_AND: v = a & b;
        default: begin
          r = res_of(ST_BAD_FN, 1'b0, 3'd0, 32'd0);
        end
      endcase
      if (r.wrote) begin
        r.value = v;
        gpr_model[rd] = v;
      end
    end else if (op == OP_ADDI) begin
      v = a + {26'd0, imm};
      gpr_model[rt] = v;
      r = res_of(ST_ADDI, 1'b1, rt, v);
    end else if (op == OP_LW || op == OP_SW || op == OP_BEQ || op == OP_J) begin
      r.status = ST_FLAGGED;
    end
    return r;
  endfunction

  function automatic logic [15:0] rand_instr();
    int          pick;
    logic [2:0]  fn_sel;
    logic [3:0]  op_sel;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      case ($urandom_range(0, 3))
        0:       fn_sel = FN_ADD;
        1:       fn_sel = FN_SUB;
        2:       fn_sel = FN_OR;
        default: fn_sel = FN_AND;
      endcase
      return r_op(fn_sel, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                  3'($urandom_range(0, 7)));
    end else if (pick < 75) begin
      return i_op(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                  6'($urandom_range(0, 63)));
    end else if (pick < 82) begin
      fn_sel = 3'($urandom_range(0, 7));
      while (fn_sel == FN_ADD || fn_sel == FN_SUB || fn_sel == FN_OR || fn_sel == FN_AND)
        fn_sel = 3'($urandom_range(0, 7));
      return {OP_RTYPE, 9'($urandom_range(0, 511)), fn_sel};
    end else if (pick < 90) begin
      case ($urandom_range(0, 3))
        0:       op_sel = OP_LW;
        1:       op_sel = OP_SW;
        2:       op_sel = OP_BEQ;
        default: op_sel = OP_J;
      endcase
      return {op_sel, 12'($urandom_range(0, 4095))};
    end
    return 16'($urandom_range(0, 65535));
  endfunction

  task automatic send_beat(input logic [15:0] w, input bit typed, input exec_res_t want,
                           input int idle_pct);
    exec_res_t predicted;
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = exec_instr(w);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin : result_check
    exec_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %h", $time, out_tdata);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(want.status), 32'(out_tdata[2:0]));
        check_field("wrote", 32'(want.wrote), 32'(out_tdata[3]));
        check_field("dest_reg", 32'(want.dest), 32'(out_tdata[6:4]));
        check_field("write_value", want.value, out_tdata[38:7]);
        check_field("pad", 32'd0, 32'(out_tdata[39]));
      end
    end
  end

  initial begin : stimulus
    exec_res_t none_res;
    int        idle_tab  [4];
    int        stall_tab [4];
    idle_tab  = '{0, 80, 0, 19};
    stall_tab = '{0, 0, 80, 19};
    for (int i = 0; i < 8; i++) gpr_model[i] = 32'd0;
    none_res = res_of(ST_RTYPE, 1'b0, 3'd0, 32'd0);

    directed_rows.push_back(row(r_op(FN_ADD, 3'd3, 3'd0, 3'd0), 1,
                                res_of(ST_RTYPE, 1'b1, 3'd3, 32'd0)));
    directed_rows.push_back(row(i_op(3'd1, 3'd0, 6'd63), 1,
                                res_of(ST_ADDI, 1'b1, 3'd1, 32'd63)));
    directed_rows.push_back(row(i_op(3'd2, 3'd1, 6'd63), 0, none_res));
    directed_rows.push_back(row(r_op(FN_SUB, 3'd3, 3'd0, 3'd1), 0, none_res));
    directed_rows.push_back(row(r_op(FN_ADD, 3'd4, 3'd3, 3'd2), 0, none_res));
    directed_rows.push_back(row(r_op(FN_OR, 3'd5, 3'd3, 3'd2), 0, none_res));
    directed_rows.push_back(row(r_op(FN_AND, 3'd6, 3'd3, 3'd2), 0, none_res));
    directed_rows.push_back(row(i_op(3'd7, 3'd0, 6'd1), 0, none_res));
    directed_rows.push_back(row(r_op(FN_SUB, 3'd6, 3'd0, 3'd7), 0, none_res));
    directed_rows.push_back(row(r_op(FN_ADD, 3'd5, 3'd6, 3'd7), 0, none_res));
    directed_rows.push_back(row(r_op(FN_ADD, 3'd5, 3'd6, 3'd6), 0, none_res));
    directed_rows.push_back(row(16'h4FFF, 0, none_res));
    directed_rows.push_back(row(i_op(3'd0, 3'd6, 6'd0), 0, none_res));
    directed_rows.push_back(row(r_op(FN_SUB, 3'd0, 3'd0, 3'd0), 0, none_res));
    directed_rows.push_back(row(16'h0001, 1, res_of(ST_BAD_FN, 1'b0, 3'd0, 32'd0)));
    directed_rows.push_back(row(16'h0FFB, 1, res_of(ST_BAD_FN, 1'b0, 3'd0, 32'd0)));
    directed_rows.push_back(row(16'h0E06, 1, res_of(ST_BAD_FN, 1'b0, 3'd0, 32'd0)));
    directed_rows.push_back(row(16'h0FFF, 1, res_of(ST_BAD_FN, 1'b0, 3'd0, 32'd0)));
    directed_rows.push_back(row({OP_LW, 12'hFFF}, 1, res_of(ST_FLAGGED, 1'b0, 3'd0, 32'd0)));
    directed_rows.push_back(row({OP_SW, 12'h123}, 1, res_of(ST_FLAGGED, 1'b0, 3'd0, 32'd0)));
    directed_rows.push_back(row({OP_BEQ, 12'h000}, 1, res_of(ST_FLAGGED, 1'b0, 3'd0, 32'd0)));
    directed_rows.push_back(row({OP_J, 12'hA5A}, 1, res_of(ST_FLAGGED, 1'b0, 3'd0, 32'd0)));
    directed_rows.push_back(row(16'h1FFF, 1, res_of(ST_BAD_OP, 1'b0, 3'd0, 32'd0)));
    directed_rows.push_back(row(16'h7000, 1, res_of(ST_BAD_OP, 1'b0, 3'd0, 32'd0)));
    directed_rows.push_back(row(16'hE5A5, 1, res_of(ST_BAD_OP, 1'b0, 3'd0, 32'd0)));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_beat(directed_rows[i].instr, directed_rows[i].typed, directed_rows[i].want, 0);
    drain_results();

    for (int ph = 0; ph < 4; ph++) begin
      stall_pct = stall_tab[ph];
      for (int n = 0; n < RAND_ITEMS / 4; n++)
        send_beat(rand_instr(), 0, none_res, idle_tab[ph]);
      drain_results();
    end

    stall_pct = 0;
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/mrde_pkg.sv
rtl/mrde_front.sv
rtl/mrde_queue.sv
rtl/mrde_back.sv
rtl/mini_risc_decode_execute.sv
rtl/mrde_checker.sv
bench/tb_mini_risc_decode_execute.sv
